/* hdl/sphere_frustum_classify_assert.svh */
// Assertion macros used by the sphere frustum classifier top level.
// Depends on nothing; included by the top level.
`ifndef SPHERE_FRUSTUM_CLASSIFY_ASSERT_SVH
`define SPHERE_FRUSTUM_CLASSIFY_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SFC_ASSERT_NOW(lbl, clk_i, rst_ni, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SFC_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sfc_pkg.sv */
// Shared types, constants and helpers of the sphere frustum classifier.
// No dependencies.
`default_nettype none

package sfc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int PLANE_COUNT = 6;
    localparam int NEAR_PLANE  = 5;
    localparam int HALF_BITS   = 16;
    localparam int PLANE_BITS  = 4 * HALF_BITS;
    localparam int DIST_BITS   = 36;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] CLASS_INSIDE   = 2'd0;
    localparam logic [1:0] CLASS_CLIPPING = 2'd1;
    localparam logic [1:0] CLASS_OUTSIDE  = 2'd2;
    localparam logic [1:0] CLASS_NEAR     = 2'd3;

    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_NEAR     = 1'b1;

    typedef logic [PLANE_BITS-1:0] plane_t;

    // Per-stage load strobes.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

/* hdl/sfc_plane_bank.sv */
// Six frustum plane registers written through the configuration channel.
// Depends on sfc_pkg.
`default_nettype none

module sfc_plane_bank (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire sfc_pkg::plane_t               wr_data,
    output sfc_pkg::plane_t                    planes [sfc_pkg::PLANE_COUNT]
);

    sfc_pkg::plane_t plane_reg [sfc_pkg::PLANE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++)
            begin
                if (wr_index == sfc_pkg::CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= wr_data;
                end
            end
        end
    end

    // indexes beyond the list match no register
    assign planes = plane_reg;

endmodule

`default_nettype wire

/* hdl/sfc_plane_dist.sv */
// Signed distance a*x + b*y + c*z + d of one plane, three register stages.
// Depends on sfc_pkg.
`default_nettype none

module sfc_plane_dist #(
    parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sfc_pkg::FRAC_BITS_DEF,
    localparam int PROD_W = sfc_pkg::HALF_BITS + COORD_BITS,
    localparam int D_W    = sfc_pkg::HALF_BITS + FRAC_BITS,
    localparam int PS_W   = sfc_pkg::max_int(PROD_W, D_W) + 1,
    localparam int SUM_W  = PS_W + 1
) (
    input  wire logic                          clk,
    input  wire sfc_pkg::pipe_en_t             en,
    input  wire sfc_pkg::plane_t               plane,
    input  wire logic signed [COORD_BITS-1:0]  x,
    input  wire logic signed [COORD_BITS-1:0]  y,
    input  wire logic signed [COORD_BITS-1:0]  z,
    output logic signed [SUM_W-1:0]            pdist
);

    logic signed [PROD_W-1:0] a_ext, b_ext, c_ext, x_ext, y_ext, z_ext;
    logic signed [D_W-1:0]    d_scaled;

    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [D_W-1:0]    pd_reg;
    logic signed [PS_W-1:0]   s01_reg, s23_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    assign a_ext = PROD_W'(signed'(plane[15:0]));
    assign b_ext = PROD_W'(signed'(plane[31:16]));
    assign c_ext = PROD_W'(signed'(plane[47:32]));
    assign x_ext = PROD_W'(x);
    assign y_ext = PROD_W'(y);
    assign z_ext = PROD_W'(z);
    assign d_scaled = signed'({plane[63:48], {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pa_reg <= a_ext * x_ext;
            pb_reg <= b_ext * y_ext;
            pc_reg <= c_ext * z_ext;
            pd_reg <= d_scaled;
        end
        if (en.s2)
        begin
            s01_reg <= PS_W'(pa_reg) + PS_W'(pb_reg);
            s23_reg <= PS_W'(pc_reg) + PS_W'(pd_reg);
        end
        if (en.s3)
        begin
            sum_reg <= SUM_W'(s01_reg) + SUM_W'(s23_reg);
        end
    end

    assign pdist = sum_reg;

endmodule

`default_nettype wire

/* hdl/sfc_classify.sv */
// Radius tests over six plane distances, class select and output saturation.
// Two register stages; the second is the output register. Depends on sfc_pkg.
`default_nettype none

module sfc_classify #(
    parameter int SUM_W = 34,
    parameter int RAD_W = 27,
    localparam int DR_W  = sfc_pkg::max_int(SUM_W, RAD_W + 1) + 1,
    localparam int EXT_W = sfc_pkg::max_int(DR_W, sfc_pkg::DIST_BITS)
) (
    input  wire logic                      clk,
    input  wire sfc_pkg::pipe_en_t         en,
    input  wire logic signed [SUM_W-1:0]   pdist [sfc_pkg::PLANE_COUNT],
    input  wire logic [RAD_W-1:0]          rad,
    input  wire logic                      func,
    output logic [1:0]                     clip_class,
    output logic signed [sfc_pkg::DIST_BITS-1:0] distance
);

    localparam logic signed [EXT_W-1:0] DIST_HI =
        EXT_W'({1'b0, {(sfc_pkg::DIST_BITS-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] DIST_LO = ~DIST_HI;

    logic signed [DR_W-1:0] rad_ext;
    logic signed [DR_W-1:0] plus_rad  [sfc_pkg::PLANE_COUNT];
    logic signed [DR_W-1:0] minus_rad [sfc_pkg::PLANE_COUNT];
    logic [sfc_pkg::PLANE_COUNT-1:0] outside_vec, above_vec;

    logic                   outside_reg, inside_reg, func_reg;
    logic signed [DR_W-1:0] near_sum_reg;

    logic signed [EXT_W-1:0]             near_ext;
    logic [1:0]                          class_next;
    logic signed [sfc_pkg::DIST_BITS-1:0] dist_next;
    logic [1:0]                          class_reg;
    logic signed [sfc_pkg::DIST_BITS-1:0] dist_reg;

    assign rad_ext = signed'(DR_W'(rad));

    always_comb
    begin
        for (int p = 0; p < sfc_pkg::PLANE_COUNT; p++)
        begin
            plus_rad[p]    = DR_W'(pdist[p]) + rad_ext;
            minus_rad[p]   = DR_W'(pdist[p]) - rad_ext;
            outside_vec[p] = (plus_rad[p] <= 0);
            above_vec[p]   = (minus_rad[p] > 0);
        end
    end

    always_comb
    begin
        near_ext = EXT_W'(near_sum_reg);
        if (near_ext > DIST_HI)
        begin
            dist_next = DIST_HI[sfc_pkg::DIST_BITS-1:0];
        end
        else if (near_ext < DIST_LO)
        begin
            dist_next = DIST_LO[sfc_pkg::DIST_BITS-1:0];
        end
        else
        begin
            dist_next = near_ext[sfc_pkg::DIST_BITS-1:0];
        end

        if (func_reg == sfc_pkg::FUNC_NEAR)
        begin
            class_next = sfc_pkg::CLASS_NEAR;
        end
        else if (outside_reg)
        begin
            class_next = sfc_pkg::CLASS_OUTSIDE;
            dist_next  = '0;
        end
        else if (inside_reg)
        begin
            class_next = sfc_pkg::CLASS_INSIDE;
        end
        else
        begin
            class_next = sfc_pkg::CLASS_CLIPPING;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            outside_reg  <= |outside_vec;
            inside_reg   <= &above_vec;
            func_reg     <= func;
            near_sum_reg <= plus_rad[sfc_pkg::NEAR_PLANE];
        end
        if (en.s5)
        begin
            class_reg <= class_next;
            dist_reg  <= dist_next;
        end
    end

    assign clip_class = class_reg;
    assign distance   = dist_reg;

endmodule

`default_nettype wire

/* hdl/sphere_frustum_classify.sv */
// Sphere frustum classifier top level; uses sfc_pkg, sfc_plane_bank,
// sfc_plane_dist, sfc_classify and sphere_frustum_classify_assert.svh.
// Pipeline: an accepted sphere passes five register stages, s1 through s5;
// out_valid is the valid bit of s5, the output register.
// Throughput: one sphere per cycle; a full stage holds only while the next can't load.
// Reset: async active low; clears all stage valid bits and the six planes to 0.
`default_nettype none

`include "sphere_frustum_classify_assert.svh"

module sphere_frustum_classify #(
    parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfc_pkg::PLANE_BITS-1:0] cfg_data,

    // sphere input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic signed [COORD_BITS-1:0]  center_x,
    input  wire logic signed [COORD_BITS-1:0]  center_y,
    input  wire logic signed [COORD_BITS-1:0]  center_z,
    input  wire logic [COORD_BITS-2:0]         sphere_radius,

    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         clip_class,
    output logic signed [sfc_pkg::DIST_BITS-1:0] distance
);

    // Widths of the distance datapath (must match sfc_plane_dist).
    localparam int PROD_W = sfc_pkg::HALF_BITS + COORD_BITS;
    localparam int D_W    = sfc_pkg::HALF_BITS + FRAC_BITS;
    localparam int SUM_W  = sfc_pkg::max_int(PROD_W, D_W) + 2;
    // Radius scaled to Q.24 is the raw radius shifted up by FRAC_BITS.
    localparam int RAD_W  = COORD_BITS - 1 + FRAC_BITS;
    localparam int STAGES = 5;

    // ------------------------------------------------------------------
    // Plane registers. Writes are always taken; indexes past the near
    // plane are dropped inside the bank.
    // ------------------------------------------------------------------
    sfc_pkg::plane_t planes [sfc_pkg::PLANE_COUNT];

    assign cfg_ready = 1'b1;

    sfc_plane_bank u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .planes   (planes)
    );

    // ------------------------------------------------------------------
    // Pipeline control. Stage k may load when it is empty or when stage
    // k+1 is loading too; the last stage is the output register, so a
    // waiting result only blocks the stages that are actually full.
    //   s1: products          s2: pair sums       s3: plane distance
    //   s4: radius tests      s5: class / saturate (output)
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_rdy;
    sfc_pkg::pipe_en_t en;

    always_comb
    begin
        stage_rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_rdy[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (stage_rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    // load strobes only fire when a valid item moves in
    assign en.s1 = stage_rdy[0] && in_valid;
    assign en.s2 = stage_rdy[1] && valid_reg[0];
    assign en.s3 = stage_rdy[2] && valid_reg[1];
    assign en.s4 = stage_rdy[3] && valid_reg[2];
    assign en.s5 = stage_rdy[4] && valid_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = valid_reg[STAGES-1];

    // ------------------------------------------------------------------
    // Side payload: mode bit and radius ride along the distance stages.
    // ------------------------------------------------------------------
    logic             func_s1_reg, func_s2_reg, func_s3_reg;
    logic [RAD_W-1:0] rad_s1_reg, rad_s2_reg, rad_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            func_s1_reg <= func;
            rad_s1_reg  <= {sphere_radius, {FRAC_BITS{1'b0}}};
        end
        if (en.s2)
        begin
            func_s2_reg <= func_s1_reg;
            rad_s2_reg  <= rad_s1_reg;
        end
        if (en.s3)
        begin
            func_s3_reg <= func_s2_reg;
            rad_s3_reg  <= rad_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Six plane distance lanes, all computed every item; near mode just
    // ignores the first five downstream.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] pdist [sfc_pkg::PLANE_COUNT];

    for (genvar p = 0; p < sfc_pkg::PLANE_COUNT; p++)
    begin : g_lane
        sfc_plane_dist #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_dist (
            .clk   (clk),
            .en    (en),
            .plane (planes[p]),
            .x     (center_x),
            .y     (center_y),
            .z     (center_z),
            .pdist (pdist[p])
        );
    end

    // ------------------------------------------------------------------
    // Radius tests and output register. Outside wins over everything in
    // classify mode and forces distance to zero.
    // ------------------------------------------------------------------
    sfc_classify #(
        .SUM_W (SUM_W),
        .RAD_W (RAD_W)
    ) u_classify (
        .clk        (clk),
        .en         (en),
        .pdist      (pdist),
        .rad        (rad_s3_reg),
        .func       (func_s3_reg),
        .clip_class (clip_class),
        .distance   (distance)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SFC_ASSERT_NOW(a_outside_zero, clk, rst_n,
        out_valid && (clip_class == sfc_pkg::CLASS_OUTSIDE), distance == '0,
        "outside result with nonzero distance")
    `SFC_ASSERT_NOW(a_empty_out_ready, clk, rst_n, !out_valid, in_ready,
        "input stalled while output register empty")
    `SFC_ASSERT_NOW(a_out_from_s4, clk, rst_n, $rose(out_valid), $past(valid_reg[STAGES-2]),
        "result appeared without an item in the radius stage")

endmodule

`default_nettype wire

/* tb/sfc_checker.sv */
// Result checker for the sphere frustum classifier: tracks plane writes,
// predicts each sphere's class and distance, and compares the results in order.
// Depends on sfc_pkg.
`timescale 1ns / 100ps

module sfc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfc_pkg::PLANE_BITS-1:0]     cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               func,
    input  logic signed [sfc_pkg::COORD_BITS_DEF-1:0] center_x,
    input  logic signed [sfc_pkg::COORD_BITS_DEF-1:0] center_y,
    input  logic signed [sfc_pkg::COORD_BITS_DEF-1:0] center_z,
    input  logic [sfc_pkg::COORD_BITS_DEF-2:0] sphere_radius,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [1:0]                         clip_class,
    input  logic signed [sfc_pkg::DIST_BITS-1:0] distance,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 results_checked,
    output logic [3:0]                         classes_hit
);

    localparam int CW = sfc_pkg::COORD_BITS_DEF;
    localparam int FB = sfc_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [1:0]                           cls;
        logic signed [sfc_pkg::DIST_BITS-1:0] dist_q24;
    } sphere_result_t;

    logic [sfc_pkg::PLANE_BITS-1:0] planes [sfc_pkg::PLANE_COUNT];
    sphere_result_t                 pending_results [$];
    sphere_result_t                 want;
    int                             fail_count;

    // a*x + b*y + c*z + d, all in Q.24; exact at the default sizes
    function automatic longint plane_distance(input int p,
                                              input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] z);
        longint ca, cb, cc, cd;
        ca = longint'($signed(planes[p][15:0]));
        cb = longint'($signed(planes[p][31:16]));
        cc = longint'($signed(planes[p][47:32]));
        cd = longint'($signed(planes[p][63:48]));
        return ca * longint'(x) + cb * longint'(y) + cc * longint'(z) + (cd <<< FB);
    endfunction

    function automatic sphere_result_t classify_sphere(input logic fn,
                                                       input logic signed [CW-1:0] x,
                                                       input logic signed [CW-1:0] y,
                                                       input logic signed [CW-1:0] z,
                                                       input logic [CW-2:0] r);
        sphere_result_t res;
        longint         rad, d_cur, lim;
        int             above, p;
        bit             culled;
        rad    = longint'(r) <<< FB;
        lim    = (longint'(1) <<< (sfc_pkg::DIST_BITS - 1)) - 1;
        above  = 0;
        culled = 1'b0;
        d_cur  = 0;
        res.cls      = sfc_pkg::CLASS_NEAR;
        res.dist_q24 = '0;
        if (fn == sfc_pkg::FUNC_NEAR)
            d_cur = plane_distance(sfc_pkg::NEAR_PLANE, x, y, z);
        else
            for (p = 0; p < sfc_pkg::PLANE_COUNT && !culled; p++)
            begin
                d_cur = plane_distance(p, x, y, z);
                if (d_cur <= -rad)
                    culled = 1'b1;
                else if (d_cur > rad)
                    above++;
            end
        if (culled)
            res.cls = sfc_pkg::CLASS_OUTSIDE;
        else
        begin
            if (fn == sfc_pkg::FUNC_CLASSIFY)
                res.cls = (above == sfc_pkg::PLANE_COUNT) ? sfc_pkg::CLASS_INSIDE
                                                          : sfc_pkg::CLASS_CLIPPING;
            // near plane is last, so d_cur holds its distance here
            d_cur = d_cur + rad;
            if (d_cur > lim)
                d_cur = lim;
            if (d_cur < -lim - 1)
                d_cur = -lim - 1;
            res.dist_q24 = d_cur[sfc_pkg::DIST_BITS-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++)
                planes[i] = '0;
            pending_results.delete();
            fail_count = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
            classes_hit     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < sfc_pkg::PLANE_COUNT)
                planes[cfg_index] = cfg_data;

            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: clip_class %0d distance %0d",
                           clip_class, distance);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (clip_class !== want.cls)
                    begin
                        $error("clip_class: expected %0d, actual %0d", want.cls, clip_class);
                        fail_count++;
                    end
                    if (distance !== want.dist_q24)
                    begin
                        $error("distance: expected %0d, actual %0d", want.dist_q24, distance);
                        fail_count++;
                    end
                    classes_hit[want.cls] <= 1'b1;
                end
                results_checked <= results_checked + 1;
            end

            if (in_valid && in_ready)
                pending_results.insert(pending_results.size(),
                                       classify_sphere(func, center_x, center_y,
                                                       center_z, sphere_radius));

            mismatches  <= fail_count;
            outstanding <= pending_results.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for sphere_frustum_classify: clock, reset, plane loads,
// sphere stimulus and the result-side stall pattern. Uses sfc_pkg and sfc_checker.
`timescale 1ns / 100ps

module tb;

    localparam int CW      = sfc_pkg::COORD_BITS_DEF;
    localparam int ONE     = 1 << sfc_pkg::FRAC_BITS_DEF;   // 1.0 in Q3.12
    localparam int RAD_MAX = (1 << (CW - 1)) - 1;           // largest radius code

    // register indexes below the near plane (near comes from the package)
    localparam int RIGHT_PLANE  = 0;
    localparam int LEFT_PLANE   = 1;
    localparam int BOTTOM_PLANE = 2;
    localparam int TOP_PLANE    = 3;
    localparam int FAR_PLANE    = 4;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 225;
    localparam int HOLD_CYCLES   = 200;   // long result-side hold-off
    localparam int BURST_ITEMS   = 60;    // back-to-back spheres during the hold-off
    localparam int DRAIN_CYCLES  = 20;    // five-stage pipe plus margin

    typedef enum int {
        SET_ZERO,
        SET_UNIT_BOX,
        SET_SCALED_BOX,
        SET_RANDOM,
        SET_EXTREME
    } plane_set_e;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [sfc_pkg::PLANE_BITS-1:0]   cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic                             func;
    logic signed [CW-1:0]             center_x;
    logic signed [CW-1:0]             center_y;
    logic signed [CW-1:0]             center_z;
    logic [CW-2:0]                    sphere_radius;
    logic                             out_valid;
    logic                             out_ready;
    logic [1:0]                       clip_class;
    logic signed [sfc_pkg::DIST_BITS-1:0] distance;

    int                               mismatches;
    int                               outstanding;
    int                               results_checked;
    logic [3:0]                       classes_hit;

    logic [sfc_pkg::PLANE_BITS-1:0]   frustum [sfc_pkg::PLANE_COUNT];
    int                               spheres_sent;
    int                               plane_loads;
    int                               burst_left;
    bit                               hold_req;

    sphere_frustum_classify dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .clip_class    (clip_class),
        .distance      (distance)
    );

    sfc_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .center_x        (center_x),
        .center_y        (center_y),
        .center_z        (center_z),
        .sphere_radius   (sphere_radius),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .clip_class      (clip_class),
        .distance        (distance),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .classes_hit     (classes_hit)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hard stop. The slowest legal run (every gap and stall at its longest)
    // stays well under a third of this.
    initial
    begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    // Plane word layout: a in the low halfword, d in the high one.
    function automatic logic [sfc_pkg::PLANE_BITS-1:0] pack_plane(input int a, input int b,
                                                                  input int c, input int d);
        return {sfc_pkg::HALF_BITS'(d), sfc_pkg::HALF_BITS'(c),
                sfc_pkg::HALF_BITS'(b), sfc_pkg::HALF_BITS'(a)};
    endfunction

    // Sender gap: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Mostly near the unit frustum, the rest anywhere in the Q3.12 range.
    function automatic logic signed [CW-1:0] rand_coord();
        if ($urandom_range(0, 9) < 6)
            return CW'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
        return CW'($urandom);
    endfunction

    // Sender stops until the pipe is empty. The first edge is always waited
    // out since the count from the checker is registered and lags the transfers.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Build a plane set and write it, then poke the two unused indexes with junk
    // (the block must drop those writes). Only called with the pipe empty.
    task automatic apply_planes(input plane_set_e kind);
        int k, i, rot;
        k   = (kind == SET_UNIT_BOX) ? ONE : $urandom_range(ONE / 2, 2 * ONE);
        rot = $urandom_range(0, 3);
        for (i = 0; i < sfc_pkg::PLANE_COUNT; i++)
        begin
            case (kind)
                SET_ZERO:
                    frustum[i] = '0;
                SET_RANDOM:
                    frustum[i] = {$urandom, $urandom};
                SET_EXTREME:
                    case ((i + rot) % 4)
                        0:       frustum[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                        1:       frustum[i] = 64'h8000_8000_8000_8000;
                        2:       frustum[i] = 64'hFFFF_FFFF_FFFF_FFFF;
                        default: frustum[i] = 64'h7FFF_8000_0001_7FFF;
                    endcase
                default:
                    frustum[i] = '0;
            endcase
        end
        // axis-aligned box: each plane faces inward, offset in d
        if (kind == SET_UNIT_BOX || kind == SET_SCALED_BOX)
        begin
            frustum[RIGHT_PLANE]  = pack_plane(-k, 0, 0, (kind == SET_UNIT_BOX) ? ONE :
                                               $urandom_range(ONE / 4, 3 * ONE));
            frustum[LEFT_PLANE]   = pack_plane(k, 0, 0, (kind == SET_UNIT_BOX) ? ONE :
                                               $urandom_range(ONE / 4, 3 * ONE));
            frustum[BOTTOM_PLANE] = pack_plane(0, k, 0, (kind == SET_UNIT_BOX) ? ONE :
                                               $urandom_range(ONE / 4, 3 * ONE));
            frustum[TOP_PLANE]    = pack_plane(0, -k, 0, (kind == SET_UNIT_BOX) ? ONE :
                                               $urandom_range(ONE / 4, 3 * ONE));
            frustum[FAR_PLANE]    = pack_plane(0, 0, -k, (kind == SET_UNIT_BOX) ? ONE :
                                               $urandom_range(ONE / 4, 3 * ONE));
            frustum[sfc_pkg::NEAR_PLANE] = pack_plane(0, 0, k, (kind == SET_UNIT_BOX) ? ONE :
                                               $urandom_range(ONE / 4, 3 * ONE));
        end
        // cfg_valid stays up across the writes and drops once after the last
        for (i = 0; i < (1 << sfc_pkg::CFG_IDX_W); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= sfc_pkg::CFG_IDX_W'(i);
            cfg_data  <= (i < sfc_pkg::PLANE_COUNT) ? frustum[i] : {$urandom, $urandom};
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        plane_loads++;
    endtask

    // One sphere transfer. A gap (or a full drain) drops in_valid first; with
    // no gap valid simply stays up and the payload changes.
    task automatic send_sphere(input logic fn, input int x, input int y,
                               input int z, input int r);
        int gap;
        bit pause;
        gap   = (burst_left > 0) ? 0 : pick_gap();
        pause = (burst_left == 0) && ($urandom_range(0, 199) == 0);
        if (burst_left > 0)
            burst_left--;
        if (gap > 0 || pause)
        begin
            in_valid <= 1'b0;
            if (pause)
                wait_drained();
            else
                repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= fn;
        center_x      <= CW'(x);
        center_y      <= CW'(y);
        center_z      <= CW'(z);
        sphere_radius <= (CW-1)'(r);
        do
            @(posedge clk);
        while (!in_ready);
        spheres_sent++;
    endtask

    task automatic random_sphere();
        logic          fn;
        logic [CW-2:0] r;
        int            roll;
        fn   = ($urandom_range(0, 3) == 0) ? sfc_pkg::FUNC_NEAR : sfc_pkg::FUNC_CLASSIFY;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            r = '0;
        else if (roll < 6)
            r = (CW-1)'($urandom_range(0, 2 * ONE));
        else
            r = (CW-1)'($urandom);
        send_sphere(fn, int'(rand_coord()), int'(rand_coord()), int'(rand_coord()),
                    int'(r));
    endtask

    // Drop valid on the edge of the last transfer, then wait for the pipe to empty.
    task automatic end_phase();
        in_valid <= 1'b0;
        wait_drained();
    endtask

    // Result side: ready runs (sometimes long, to give stall-free stretches)
    // alternating with stalls, mostly short. On request it holds off so the
    // pipe fills and in_ready falls.
    initial
    begin
        int run_len, stall_len, roll;
        out_ready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
            roll = $urandom_range(0, 99);
            if (roll < 85)
                stall_len = $urandom_range(1, 3);
            else if (roll < 98)
                stall_len = $urandom_range(4, 12);
            else
                stall_len = $urandom_range(20, 50);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            out_ready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int ph, n;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = sfc_pkg::FUNC_CLASSIFY;
        center_x      = '0;
        center_y      = '0;
        center_z      = '0;
        sphere_radius = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        spheres_sent  = 0;
        plane_loads   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Planes still at reset: every distance is 0, so a zero radius culls
        // and any positive radius clips.
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 0, 0, 0, 0);
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 100, -100, 7, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_NEAR, -5, 5, 0, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_NEAR, 0, 0, 0, 0);
        end_phase();

        // Unit cube frustum, |x|,|y|,|z| <= 1.0
        apply_planes(SET_UNIT_BOX);
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 0, 0, 0, 0);              // inside, zero radius
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 0, 0, 0, ONE / 4);        // inside
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 0, 0, 0, ONE);            // distance equals radius
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 2 * ONE, 0, 0, ONE);      // exactly minus radius
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 2 * ONE - 1, 0, 0, ONE);  // one LSB short: clip
        send_sphere(sfc_pkg::FUNC_CLASSIFY, ONE, 0, 0, 0);            // zero radius on plane
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 0, 0, -ONE / 2, ONE / 8); // inside, near side
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 0, -2 * ONE, 0, 2 * ONE); // straddles bottom
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 32767, 32767, 32767, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_CLASSIFY, -32768, -32768, -32768, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_CLASSIFY, -32768, 32767, -32768, 0);
        send_sphere(sfc_pkg::FUNC_NEAR, 32767, -32768, 32767, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_NEAR, -32768, -32768, -32768, 0);
        send_sphere(sfc_pkg::FUNC_NEAR, 0, 0, 0, 0);
        end_phase();

        // Full-scale coefficients against full-scale centers: largest distances
        apply_planes(SET_EXTREME);
        send_sphere(sfc_pkg::FUNC_NEAR, 32767, 32767, 32767, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_NEAR, -32768, -32768, -32768, RAD_MAX);
        send_sphere(sfc_pkg::FUNC_CLASSIFY, 32767, 32767, 32767, 0);
        send_sphere(sfc_pkg::FUNC_CLASSIFY, -32768, -32768, -32768, RAD_MAX);
        end_phase();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       apply_planes(SET_SCALED_BOX);
                1:       apply_planes(SET_RANDOM);
                2:       apply_planes(SET_UNIT_BOX);
                3:       apply_planes(SET_EXTREME);
                4:       apply_planes(SET_ZERO);
                default: apply_planes(SET_SCALED_BOX);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // back-pressure episode: result side holds while spheres keep coming
                if (ph == 0 && n == 40)
                begin
                    hold_req   = 1'b1;
                    burst_left = BURST_ITEMS;
                end
                random_sphere();
            end
            end_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d spheres over %0d plane loads, %0d results checked",
                 spheres_sent, plane_loads, results_checked);
        $display("tb: classes seen (near/outside/clipping/inside) = %b", classes_hit);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/sfc_pkg.sv
hdl/sfc_plane_bank.sv
hdl/sfc_plane_dist.sv
hdl/sfc_classify.sv
hdl/sphere_frustum_classify.sv
tb/sfc_checker.sv
tb/tb.sv
